// ===== rtl/oal_pkg.sv =====
`timescale 1ns / 1ps

package oal_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 7;
   localparam int VAL_W  = 32;
   localparam int CMD_W  = 3;
   localparam int ST_W   = 2;
   // Wide enough to compare a position with the count without losing bits.
   localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;

   localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND       = 3'd4;
   localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd5;
   localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd6;

   localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ST_W-1:0]   status;
      logic              found;
      logic [ADDR_W-1:0] found_index;
      logic [CNT_W-1:0]  count;
   } rsp_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [VAL_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

endpackage

// ===== rtl/oal_ram.sv =====
`timescale 1ns / 1ps

module oal_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/oal_ctrl.sv =====
`timescale 1ns / 1ps

module oal_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  oal_pkg::req_type              req,
   input  logic                          slot_free,
   input  logic [oal_pkg::VAL_W-1:0]     rd_data,
   output oal_pkg::mem_req_type          mem_req,
   output logic                          idle,
   output logic                          done,
   output oal_pkg::rsp_type              rsp
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_WALK = 2'd1;
   localparam logic [1:0] S_LAST = 2'd2;

   localparam logic [2:0] MODE_NONE  = 3'd0;
   localparam logic [2:0] MODE_OPEN  = 3'd1;
   localparam logic [2:0] MODE_CLOSE = 3'd2;
   localparam logic [2:0] MODE_POPB  = 3'd3;
   localparam logic [2:0] MODE_FIND  = 3'd4;

   logic [1:0]                   state_ff, state_in;
   logic [2:0]                   mode_ff, mode_in;
   logic [oal_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [oal_pkg::ADDR_W-1:0]   pos_ff, pos_in;
   logic [oal_pkg::VAL_W-1:0]    value_ff, value_in;
   logic [oal_pkg::ADDR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [oal_pkg::ADDR_W-1:0]   rd_end_ff, rd_end_in;
   logic                         more_ff, more_in;
   logic                         pend_ff, pend_in;
   logic [oal_pkg::ADDR_W-1:0]   pend_addr_ff, pend_addr_in;
   logic [oal_pkg::ST_W-1:0]     status_ff, status_in;
   logic                         found_ff, found_in;
   logic [oal_pkg::ADDR_W-1:0]   index_ff, index_in;

   logic [oal_pkg::CMP_W-1:0]    cnt_ext;
   logic [oal_pkg::CMP_W-1:0]    pos_ext;
   logic [oal_pkg::CMP_W-1:0]    op_pos;
   logic                         full;
   logic                         empty;
   logic                         do_open;
   logic                         do_close;
   logic                         hit;

   assign cnt_ext = oal_pkg::CMP_W'(count_ff);
   assign pos_ext = oal_pkg::CMP_W'(req.position);
   assign full    = (count_ff == oal_pkg::CNT_W'(oal_pkg::DEPTH));
   assign empty   = (count_ff == '0);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_end_in    = rd_end_ff;
      more_in      = more_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      index_in     = index_ff;
      mem_req      = '0;
      done         = 1'b0;
      op_pos       = '0;
      do_open      = 1'b0;
      do_close     = 1'b0;
      hit          = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               value_in  = req.value;
               status_in = oal_pkg::ST_DONE;
               found_in  = 1'b0;
               index_in  = '0;
               mode_in   = MODE_NONE;
               more_in   = 1'b0;
               pend_in   = 1'b0;
               case (req.command)
                  oal_pkg::CMD_PUSH_FRONT: begin
                     if (full) status_in = oal_pkg::ST_FULL;
                     else do_open = 1'b1;
                  end
                  oal_pkg::CMD_PUSH_BACK: begin
                     if (full) begin
                        status_in = oal_pkg::ST_FULL;
                     end else begin
                        do_open = 1'b1;
                        op_pos  = cnt_ext;
                     end
                  end
                  oal_pkg::CMD_POP_FRONT: begin
                     if (empty) status_in = oal_pkg::ST_EMPTY;
                     else do_close = 1'b1;
                  end
                  oal_pkg::CMD_POP_BACK: begin
                     if (empty) status_in = oal_pkg::ST_EMPTY;
                     else mode_in = MODE_POPB;
                  end
                  oal_pkg::CMD_FIND: begin
                     if (empty) begin
                        status_in = oal_pkg::ST_EMPTY;
                     end else begin
                        mode_in   = MODE_FIND;
                        rd_ptr_in = '0;
                        rd_end_in = oal_pkg::ADDR_W'(cnt_ext - 1'b1);
                        more_in   = 1'b1;
                     end
                  end
                  oal_pkg::CMD_INSERT: begin
                     if (full) begin
                        status_in = oal_pkg::ST_FULL;
                     end else if (pos_ext > cnt_ext) begin
                        status_in = oal_pkg::ST_RANGE;
                     end else begin
                        do_open = 1'b1;
                        op_pos  = pos_ext;
                     end
                  end
                  oal_pkg::CMD_ERASE: begin
                     if (empty) begin
                        status_in = oal_pkg::ST_EMPTY;
                     end else if (pos_ext >= cnt_ext) begin
                        status_in = oal_pkg::ST_RANGE;
                     end else begin
                        do_close = 1'b1;
                        op_pos   = pos_ext;
                     end
                  end
                  default: begin
                  end
               endcase

               // Opening a gap walks from the last entry down to the gap;
               // closing one walks from just above the gap up to the last entry.
               if (do_open) begin
                  mode_in   = MODE_OPEN;
                  pos_in    = oal_pkg::ADDR_W'(op_pos);
                  rd_ptr_in = oal_pkg::ADDR_W'(cnt_ext - 1'b1);
                  rd_end_in = oal_pkg::ADDR_W'(op_pos);
                  more_in   = (cnt_ext > op_pos);
               end
               if (do_close) begin
                  mode_in   = MODE_CLOSE;
                  pos_in    = oal_pkg::ADDR_W'(op_pos);
                  rd_ptr_in = oal_pkg::ADDR_W'(op_pos + 1'b1);
                  rd_end_in = oal_pkg::ADDR_W'(cnt_ext - 1'b1);
                  more_in   = ((op_pos + 1'b1) < cnt_ext);
               end
               state_in = more_in ? S_WALK : S_LAST;
            end
         end

         S_WALK: begin
            // The entry read in the previous cycle is now on rd_data.
            if (pend_ff) begin
               case (mode_ff)
                  MODE_OPEN: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pend_addr_ff + 1'b1;
                     mem_req.wr_data = rd_data;
                  end
                  MODE_CLOSE: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pend_addr_ff - 1'b1;
                     mem_req.wr_data = rd_data;
                  end
                  MODE_FIND: begin
                     if (rd_data == value_ff) begin
                        hit      = 1'b1;
                        found_in = 1'b1;
                        index_in = pend_addr_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end

            if (more_ff && !hit) begin
               mem_req.rd_en = 1'b1;
               mem_req.rd_addr = rd_ptr_ff;
               pend_in         = 1'b1;
               pend_addr_in    = rd_ptr_ff;
               if (rd_ptr_ff == rd_end_ff) begin
                  more_in = 1'b0;
               end else if (mode_ff == MODE_OPEN) begin
                  rd_ptr_in = rd_ptr_ff - 1'b1;
               end else begin
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
            end else begin
               pend_in  = 1'b0;
               more_in  = 1'b0;
               state_in = S_LAST;
            end
         end

         S_LAST: begin
            if (slot_free) begin
               done = 1'b1;
               case (mode_ff)
                  MODE_OPEN: begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pos_ff;
                     mem_req.wr_data = value_ff;
                     count_in        = count_ff + 1'b1;
                  end
                  MODE_CLOSE, MODE_POPB: begin
                     count_in = count_ff - 1'b1;
                  end
                  default: begin
                  end
               endcase
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         more_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         more_ff  <= more_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      rd_ptr_ff    <= rd_ptr_in;
      rd_end_ff    <= rd_end_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      index_ff     <= index_in;
   end

   assign idle            = (state_ff == S_IDLE);
   assign rsp.status      = status_ff;
   assign rsp.found       = found_ff;
   assign rsp.found_index = index_ff;
   assign rsp.count       = count_in;

endmodule

// ===== rtl/ordered_array_list_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Ports
// req       in         req_valid, req_ready, req_command, req_position, req_value
// rsp       out        rsp_valid, rsp_ready, rsp_status, rsp_found, rsp_found_index, rsp_count
//
// A command goes straight to its final step when nothing moves (push back, pop back, any error);
// a shift walks the entries that move, and a find walks until its first hit or the last entry; the
// walk reads one entry per cycle from the single-read-port entry RAM. Reset clears the count
// and the control state only; the entry RAM is not cleared. A finished beat waits in the
// output register while the next command is taken; a command holds in its final step while
// that register is still full.

module ordered_array_list_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [oal_pkg::CMD_W-1:0]         req_command,
   input  logic [oal_pkg::POS_W-1:0]         req_position,
   input  logic signed [oal_pkg::VAL_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [oal_pkg::ST_W-1:0]          rsp_status,
   output logic                              rsp_found,
   output logic [oal_pkg::ADDR_W-1:0]        rsp_found_index,
   output logic [oal_pkg::CNT_W-1:0]         rsp_count
);

   oal_pkg::req_type             req;
   oal_pkg::rsp_type             ctrl_rsp;
   oal_pkg::rsp_type             rsp_ff;
   oal_pkg::mem_req_type         mem_req;
   logic [oal_pkg::VAL_W-1:0]    rd_data;
   logic                         idle;
   logic                         done;
   logic                         start;
   logic                         slot_free;
   logic                         rsp_valid_ff, rsp_valid_in;

   assign req.command  = req_command;
   assign req.position = req_position;
   assign req.value    = req_value;

   assign req_ready = idle;
   assign start     = req_valid && idle;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   oal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .slot_free (slot_free),
      .rd_data   (rd_data),
      .mem_req   (mem_req),
      .idle      (idle),
      .done      (done),
      .rsp       (ctrl_rsp)
   );

   oal_ram #(
      .WIDTH (oal_pkg::VAL_W),
      .DEPTH (oal_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= ctrl_rsp;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_found       = rsp_ff.found;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_count       = rsp_ff.count;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import oal_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int RANDOM_ITEMS = 1530;
   localparam int QUIET_FROM   = 1330;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRILL_ROWS   = 25;

   typedef enum int {LEAN_GROW, LEAN_SEARCH, LEAN_SHRINK, LEAN_EVEN} lean_t;

   typedef struct {
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;
      bit               typed;
      rsp_type          reply;
   } drill_row_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command = '0;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [VAL_W-1:0]  req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ST_W-1:0]          rsp_status;
   logic                     rsp_found;
   logic [ADDR_W-1:0]        rsp_found_index;
   logic [CNT_W-1:0]         rsp_count;

   // Shadow copy of the list, advanced at every accepted command beat.
   logic [VAL_W-1:0] list_mem [DEPTH];
   int unsigned      list_len = 0;

   rsp_type     pending_replies [$];
   drill_row_t  drill [DRILL_ROWS];
   int          mismatches = 0;
   int          replies_seen = 0;
   int unsigned cycle_count = 0;
   bit          quiet = 1'b0;
   bit          hold_rsp = 1'b0;

   ordered_array_list_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ordered_array_list_unit regression: fail");
         $finish;
      end
   end

   // Executes one command on the shadow list and returns the reply it should give.
   function automatic rsp_type apply_command(input logic [CMD_W-1:0] cmd,
                                             input logic [POS_W-1:0] pos,
                                             input logic [VAL_W-1:0] val);
      rsp_type     r;
      int unsigned slot;
      int unsigned k;
      r = '0;
      r.status = ST_DONE;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
            slot = (cmd == CMD_PUSH_FRONT) ? 0 : (cmd == CMD_PUSH_BACK) ? list_len : pos;
            // Fullness wins over a bad position.
            if (list_len >= DEPTH) begin
               r.status = ST_FULL;
            end else if (slot > list_len) begin
               r.status = ST_RANGE;
            end else begin
               for (k = list_len; k > slot; k--) list_mem[k] = list_mem[k-1];
               list_mem[slot] = val;
               list_len++;
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK, CMD_ERASE: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               slot = (cmd == CMD_POP_FRONT) ? 0 : (cmd == CMD_POP_BACK) ? list_len - 1 : pos;
               if (slot >= list_len) begin
                  r.status = ST_RANGE;
               end else begin
                  for (k = slot + 1; k < list_len; k++) list_mem[k-1] = list_mem[k];
                  list_len--;
               end
            end
         end
         CMD_FIND: begin
            if (list_len == 0) begin
               r.status = ST_EMPTY;
            end else begin
               for (k = 0; k < list_len; k++) begin
                  if (list_mem[k] == val) begin
                     r.found = 1'b1;
                     r.found_index = k[ADDR_W-1:0];
                     break;
                  end
               end
            end
         end
         default: ;
      endcase
      r.count = list_len[CNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      mismatches++;
      $display("mismatch at reply %0d, cycle %0d: %s got %0d expected %0d",
               replies_seen, cycle_count, field, got, want);
   endtask

   // Presents one command beat and holds it until it is taken.
   task automatic offer_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] val, input bit typed,
                                input rsp_type typed_reply);
      rsp_type predicted;
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_command(cmd, pos, val);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report_mismatch("reply with nothing pending, count", rsp_count, -1);
         end else begin
            want = pending_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_found !== want.found)
               report_mismatch("found", rsp_found, want.found);
            if (rsp_found_index !== want.found_index)
               report_mismatch("found_index", rsp_found_index, want.found_index);
            if (rsp_count !== want.count)
               report_mismatch("count", rsp_count, want.count);
         end
      end
   end

   // Result side: bursts of ready and stall, one long hold-off on request.
   initial begin
      int span;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (span = 0; span < HOLD_CYCLES; span++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (quiet) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      int               n_rand;
      int               phase;
      int               span;
      int               k;
      int               grow_pct;
      int               find_pct;
      int               r;
      bit               hold_used;
      lean_t            lean;
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;

      n_rand = 0;
      phase = 0;
      hold_used = 1'b0;
      drill = '{
         '{CMD_POP_FRONT,  7'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 6'd0, 7'd0}},
         '{CMD_POP_BACK,   7'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 6'd0, 7'd0}},
         '{CMD_FIND,       7'd0,   32'd5,         1'b1, '{ST_EMPTY, 1'b0, 6'd0, 7'd0}},
         '{CMD_ERASE,      7'd0,   32'd0,         1'b1, '{ST_EMPTY, 1'b0, 6'd0, 7'd0}},
         '{CMD_UNUSED,     7'd127, 32'hFFFF_FFFF, 1'b1, '{ST_DONE,  1'b0, 6'd0, 7'd0}},
         '{CMD_INSERT,     7'd1,   32'd7,         1'b1, '{ST_RANGE, 1'b0, 6'd0, 7'd0}},
         '{CMD_INSERT,     7'd127, 32'd7,         1'b1, '{ST_RANGE, 1'b0, 6'd0, 7'd0}},
         '{CMD_INSERT,     7'd0,   32'h8000_0000, 1'b1, '{ST_DONE,  1'b0, 6'd0, 7'd1}},
         '{CMD_PUSH_BACK,  7'd0,   32'h7FFF_FFFF, 1'b1, '{ST_DONE,  1'b0, 6'd0, 7'd2}},
         '{CMD_PUSH_FRONT, 7'd0,   32'd0,         1'b1, '{ST_DONE,  1'b0, 6'd0, 7'd3}},
         '{CMD_FIND,       7'd0,   32'h7FFF_FFFF, 1'b0, '0},
         '{CMD_FIND,       7'd0,   32'hFFFF_FFFF, 1'b0, '0},
         '{CMD_INSERT,     7'd3,   32'hFFFF_FFFF, 1'b0, '0},
         '{CMD_ERASE,      7'd4,   32'd0,         1'b1, '{ST_RANGE, 1'b0, 6'd0, 7'd4}},
         '{CMD_ERASE,      7'd127, 32'd0,         1'b1, '{ST_RANGE, 1'b0, 6'd0, 7'd4}},
         '{CMD_INSERT,     7'd2,   32'h5555_5555, 1'b0, '0},
         '{CMD_PUSH_FRONT, 7'd0,   32'hAAAA_AAAA, 1'b0, '0},
         '{CMD_FIND,       7'd0,   32'hAAAA_AAAA, 1'b0, '0},
         '{CMD_PUSH_BACK,  7'd0,   32'd0,         1'b0, '0},
         '{CMD_FIND,       7'd0,   32'd0,         1'b0, '0},
         '{CMD_ERASE,      7'd1,   32'd0,         1'b0, '0},
         '{CMD_POP_FRONT,  7'd0,   32'd0,         1'b0, '0},
         '{CMD_POP_BACK,   7'd0,   32'd0,         1'b0, '0},
         '{CMD_FIND,       7'd0,   32'hFFFF_FFFF, 1'b0, '0},
         '{CMD_ERASE,      7'd0,   32'd0,         1'b0, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (k = 0; k < DRILL_ROWS; k++) begin
         if ($urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
         offer_command(drill[k].cmd, drill[k].pos, drill[k].val, drill[k].typed,
                       drill[k].reply);
      end

      // Phases lean toward growing, searching, shrinking or an even mix, so that
      // the list swings between empty and full.
      while (n_rand < RANDOM_ITEMS) begin
         lean = lean_t'(phase % 4);
         case (lean)
            LEAN_GROW:   begin grow_pct = 85; find_pct = 6;  span = $urandom_range(110, 170); end
            LEAN_SEARCH: begin grow_pct = 50; find_pct = 50; span = $urandom_range(30, 90);   end
            LEAN_SHRINK: begin grow_pct = 15; find_pct = 6;  span = $urandom_range(110, 170); end
            default:     begin grow_pct = 50; find_pct = 15; span = $urandom_range(30, 100);  end
         endcase
         if (!quiet && (phase == 2 || $urandom_range(0, 3) == 0)) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending_replies.size() != 0);
         end
         for (k = 0; k < span && n_rand < RANDOM_ITEMS; k++) begin
            if (n_rand >= HOLD_AT && !hold_used) begin
               hold_used = 1'b1;
               hold_rsp = 1'b1;
            end
            if (n_rand >= QUIET_FROM) quiet = 1'b1;
            if (!quiet && !hold_rsp && $urandom_range(0, 7) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 16)) @(posedge clock);
            end

            r = $urandom_range(0, 99);
            if (r < 2) begin
               cmd = CMD_UNUSED;
            end else if (r < 2 + find_pct) begin
               cmd = CMD_FIND;
            end else if ($urandom_range(0, 99) < grow_pct) begin
               case ($urandom_range(0, 2))
                  0:       cmd = CMD_PUSH_FRONT;
                  1:       cmd = CMD_PUSH_BACK;
                  default: cmd = CMD_INSERT;
               endcase
            end else begin
               case ($urandom_range(0, 2))
                  0:       cmd = CMD_POP_FRONT;
                  1:       cmd = CMD_POP_BACK;
                  default: cmd = CMD_ERASE;
               endcase
            end

            case ($urandom_range(0, 9))
               7:       pos = list_len[POS_W-1:0];
               8:       pos = POS_W'(list_len + 1);
               9:       pos = POS_W'($urandom_range(0, 127));
               default: pos = POS_W'($urandom_range(0, list_len));
            endcase

            // Values taken from the list itself make finds hit and leave duplicates.
            r = $urandom_range(0, 9);
            if (r < 4 && list_len > 0) begin
               val = list_mem[$urandom_range(0, list_len - 1)];
            end else if (r < 6) begin
               val = VAL_W'($signed($urandom_range(0, 8)) - 4);
            end else if (r == 8) begin
               case ($urandom_range(0, 3))
                  0:       val = 32'h8000_0000;
                  1:       val = 32'h7FFF_FFFF;
                  2:       val = 32'hFFFF_FFFF;
                  default: val = 32'd0;
               endcase
            end else begin
               val = $urandom;
            end

            offer_command(cmd, pos, val, 1'b0, '0);
            if (cmd != CMD_UNUSED) n_rand++;
         end
         phase++;
      end

      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ordered_array_list_unit regression: pass");
      else
         $display("ordered_array_list_unit regression: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/oal_pkg.sv
rtl/oal_ram.sv
rtl/oal_ctrl.sv
rtl/ordered_array_list_unit.sv
tb/tb.sv
